FILE: hdl/lfh_pkg.sv
`default_nettype none

package lfh_pkg;

    localparam int LETTER_COUNT   = 26;
    localparam int COUNT_BITS_DEF = 16;
    localparam int IDX_W          = 5;
    localparam int OUT_W          = 16;

    localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTER_COUNT - 1);

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [0:0] {
        ST_COUNT,
        ST_READOUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count_en;
        logic advance;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_term;
        logic last_index;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/lfh_ctrl.sv
`default_nettype none

module lfh_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_out_ready,
    input  lfh_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lfh_pkg::t_cmd    o_cmd
);
    import lfh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COUNT: begin
                if (i_in_valid && i_status.is_term) begin
                    n_state = ST_READOUT;
                end
            end
            ST_READOUT: begin
                if (i_out_ready && i_status.last_index) begin
                    n_state = ST_COUNT;
                end
            end
            default: n_state = ST_COUNT;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.count_en = 1'b0;
        o_cmd.advance  = 1'b0;
        o_cmd.finish   = 1'b0;
        unique case (r_state)
            ST_COUNT: begin
                o_in_ready     = 1'b1;
                o_cmd.count_en = i_in_valid && !i_status.is_term;
            end
            ST_READOUT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready;
                o_cmd.finish  = i_out_ready && i_status.last_index;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lfh_dp.sv
`default_nettype none

module lfh_dp #(
    parameter int COUNT_BITS = lfh_pkg::COUNT_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  [7:0]                 i_byte_in,
    input  lfh_pkg::t_cmd              i_cmd,
    output lfh_pkg::t_status           o_status,
    output logic [lfh_pkg::IDX_W-1:0]  o_letter_index,
    output logic [lfh_pkg::OUT_W-1:0]  o_letter_count,
    output logic [lfh_pkg::OUT_W-1:0]  o_letters_total,
    output logic [lfh_pkg::OUT_W-1:0]  o_space_total,
    output logic [lfh_pkg::OUT_W-1:0]  o_other_total,
    output logic [lfh_pkg::IDX_W-1:0]  o_top_letter,
    output logic [lfh_pkg::OUT_W-1:0]  o_top_count,
    output logic                       o_final_entry
);
    import lfh_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_cnt [LETTER_COUNT];
    logic [COUNT_BITS-1:0] r_letter_sum;
    logic [COUNT_BITS-1:0] r_space_sum;
    logic [COUNT_BITS-1:0] r_other_sum;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [IDX_W-1:0]      r_best;
    logic [IDX_W-1:0]      r_rd_idx;

    logic [7:0]            folded;
    logic [7:0]            offset;
    logic                  is_letter;
    logic                  is_space;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  take_best;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] low_bits(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    // Fold lower case onto upper case, then classify the byte.
    always_comb begin
        if (i_byte_in >= CHAR_LOWER_A && i_byte_in <= CHAR_LOWER_Z) begin
            folded = i_byte_in - CASE_OFFSET;
        end else begin
            folded = i_byte_in;
        end
        is_letter = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
        is_space  = (i_byte_in == CHAR_SPACE);
        offset    = folded - CHAR_UPPER_A;
        wr_idx    = offset[IDX_W-1:0];
        cur_cnt   = r_cnt[wr_idx];
        new_cnt   = sat_inc(cur_cnt);
        take_best = (new_cnt > r_best_cnt) ||
                    ((new_cnt == r_best_cnt) && (wr_idx < r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTER_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_letter_sum <= '0;
            r_space_sum  <= '0;
            r_other_sum  <= '0;
            r_best_cnt   <= '0;
            r_best       <= '0;
            r_rd_idx     <= '0;
        end else if (i_cmd.count_en) begin
            if (is_letter) begin
                r_cnt[wr_idx] <= new_cnt;
                r_letter_sum  <= sat_inc(r_letter_sum);
                if (take_best) begin
                    r_best     <= wr_idx;
                    r_best_cnt <= new_cnt;
                end
            end else if (is_space) begin
                r_space_sum <= sat_inc(r_space_sum);
            end else begin
                r_other_sum <= sat_inc(r_other_sum);
            end
        end else if (i_cmd.advance) begin
            // Each entry clears as it is read out; totals clear after the last one.
            r_cnt[r_rd_idx] <= '0;
            if (i_cmd.finish) begin
                r_letter_sum <= '0;
                r_space_sum  <= '0;
                r_other_sum  <= '0;
                r_best_cnt   <= '0;
                r_best       <= '0;
                r_rd_idx     <= '0;
            end else begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    assign o_status.is_term    = (i_byte_in == CHAR_NUL);
    assign o_status.last_index = (r_rd_idx == LAST_LETTER);

    assign o_letter_index  = r_rd_idx;
    assign o_letter_count  = low_bits(r_cnt[r_rd_idx]);
    assign o_letters_total = low_bits(r_letter_sum);
    assign o_space_total   = low_bits(r_space_sum);
    assign o_other_total   = low_bits(r_other_sum);
    assign o_top_letter    = r_best;
    assign o_top_count     = low_bits(r_best_cnt);
    assign o_final_entry   = (r_rd_idx == LAST_LETTER);

endmodule

`default_nettype wire

FILE: hdl/letter_frequency_histogram_unit.sv
// Latency: a non-zero byte is counted in the cycle it is accepted; a zero byte is
// followed by its first result in the next cycle.
// Throughput: one byte per cycle while counting; the readout then gives 26 results,
// one per cycle when the consumer is ready, and no byte is taken until the last one.
// Reset: synchronous, active low, clears all counters, totals and the top letter.
`default_nettype none

module letter_frequency_histogram_unit #(
    parameter int COUNT_BITS = lfh_pkg::COUNT_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [7:0]                 i_byte_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [lfh_pkg::IDX_W-1:0]  o_letter_index,
    output logic [lfh_pkg::OUT_W-1:0]  o_letter_count,
    output logic [lfh_pkg::OUT_W-1:0]  o_letters_total,
    output logic [lfh_pkg::OUT_W-1:0]  o_space_total,
    output logic [lfh_pkg::OUT_W-1:0]  o_other_total,
    output logic [lfh_pkg::IDX_W-1:0]  o_top_letter,
    output logic [lfh_pkg::OUT_W-1:0]  o_top_count,
    output logic                       o_final_entry
);
    import lfh_pkg::*;

    // The controller owns both handshakes. While counting it takes one byte per
    // cycle and tells the datapath to update a counter; a zero byte switches it
    // to the readout, where each result taken by the consumer advances the
    // read index. The datapath keeps the 26 letter counters in flip-flops, so a
    // letter can repeat in consecutive cycles without any forwarding.
    t_cmd    cmd;
    t_status status;

    lfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The most frequent letter is tracked on every increment, so the readout
    // needs no search: each result simply presents the current entry with the
    // totals and the running maximum. The counters saturate at their top value.
    lfh_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_in       (i_byte_in),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_letter_index  (o_letter_index),
        .o_letter_count  (o_letter_count),
        .o_letters_total (o_letters_total),
        .o_space_total   (o_space_total),
        .o_other_total   (o_other_total),
        .o_top_letter    (o_top_letter),
        .o_top_count     (o_top_count),
        .o_final_entry   (o_final_entry)
    );

endmodule

`default_nettype wire

FILE: hdl/lfh_checker.sv
`default_nettype none

module lfh_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire [7:0]  i_byte_in,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [4:0]  o_letter_index,
    input wire [15:0] o_letter_count,
    input wire [15:0] o_letters_total,
    input wire [15:0] o_space_total,
    input wire [15:0] o_other_total,
    input wire [4:0]  o_top_letter,
    input wire [15:0] o_top_count,
    input wire        o_final_entry
);

    // Counting and readout never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready during readout");

    // A terminator starts the readout at letter A.
    a_start_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_byte_in == 8'h00)
        |=> (o_out_valid && o_letter_index == 5'd0))
        else $error("readout did not start at letter A");

    // Results come out in letter order.
    a_next_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_final_entry)
        |=> (o_out_valid && o_letter_index == $past(o_letter_index) + 5'd1))
        else $error("readout skipped or repeated a letter");

    // After the last result the block counts again.
    a_end_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_final_entry)
        |=> (o_in_ready && !o_out_valid))
        else $error("readout did not end after letter Z");

    // The entry of the top letter carries the top count.
    a_top_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_letter_index == o_top_letter)
        |-> (o_letter_count == o_top_count))
        else $error("top count disagrees with its letter entry");

endmodule

bind letter_frequency_histogram_unit lfh_checker u_lfh_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;

    import lfh_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    // One readout row of the histogram.
    typedef struct packed {
        logic [IDX_W-1:0] letter;
        logic [OUT_W-1:0] count;
        logic [OUT_W-1:0] letters;
        logic [OUT_W-1:0] spaces;
        logic [OUT_W-1:0] others;
        logic [IDX_W-1:0] top;
        logic [OUT_W-1:0] top_cnt;
        logic             last;
    } t_hist_row;

    // Receiver behavior, re-chosen whenever its mode counter runs out.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_byte_in = 8'h00;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [IDX_W-1:0]   o_letter_index;
    logic [OUT_W-1:0]   o_letter_count;
    logic [OUT_W-1:0]   o_letters_total;
    logic [OUT_W-1:0]   o_space_total;
    logic [OUT_W-1:0]   o_other_total;
    logic [IDX_W-1:0]   o_top_letter;
    logic [OUT_W-1:0]   o_top_count;
    logic               o_final_entry;

    letter_frequency_histogram_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_letter_index  (o_letter_index),
        .o_letter_count  (o_letter_count),
        .o_letters_total (o_letters_total),
        .o_space_total   (o_space_total),
        .o_other_total   (o_other_total),
        .o_top_letter    (o_top_letter),
        .o_top_count     (o_top_count),
        .o_final_entry   (o_final_entry)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes waiting to be sent and rows the block still owes us.
    logic [7:0] sentence_bytes [$];
    t_hist_row  expected_rows [$];

    // Shadow copy of the histogram state.
    logic [OUT_W-1:0] tally [LETTER_COUNT];
    logic [OUT_W-1:0] letter_sum = '0;
    logic [OUT_W-1:0] space_sum = '0;
    logic [OUT_W-1:0] other_sum = '0;
    logic [IDX_W-1:0] best_letter = '0;
    logic [OUT_W-1:0] best_count = '0;

    int mismatch_count = 0;
    int cycle_count = 0;

    initial begin
        for (int k = 0; k < LETTER_COUNT; k++) begin
            tally[k] = '0;
        end
    end

    function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Counts one accepted byte, or on the terminator queues the 26 rows and clears.
    task automatic tally_byte(input logic [7:0] b);
        logic [7:0]       folded;
        logic [IDX_W-1:0] idx;
        t_hist_row        row;
        folded = b;
        if (b != CHAR_NUL) begin
            if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z) begin
                folded = folded - CASE_OFFSET;
            end
            if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
                idx = IDX_W'(folded - CHAR_UPPER_A);
                tally[idx] = sat_inc(tally[idx]);
                letter_sum = sat_inc(letter_sum);
                // Ties go to the lower letter.
                if (tally[idx] > best_count ||
                        (tally[idx] == best_count && idx < best_letter)) begin
                    best_letter = idx;
                    best_count  = tally[idx];
                end
            end else if (folded == CHAR_SPACE) begin
                space_sum = sat_inc(space_sum);
            end else begin
                other_sum = sat_inc(other_sum);
            end
        end else begin
            for (int k = 0; k < LETTER_COUNT; k++) begin
                row.letter  = IDX_W'(k);
                row.count   = tally[k];
                row.letters = letter_sum;
                row.spaces  = space_sum;
                row.others  = other_sum;
                row.top     = best_letter;
                row.top_cnt = best_count;
                row.last    = (IDX_W'(k) == LAST_LETTER);
                expected_rows.push_back(row);
                tally[k] = '0;
            end
            letter_sum  = '0;
            space_sum   = '0;
            other_sum   = '0;
            best_letter = '0;
            best_count  = '0;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Driver: bursts of random length with random gaps in between.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tally_byte(i_byte_in);
                void'(sentence_bytes.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // The item is still pending, so valid and payload stay put.
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (sentence_bytes.size() > 0) begin
                i_in_valid <= 1'b1;
                i_byte_in  <= sentence_bytes[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted row and stalls in modes of its own.
    t_rx_mode  rx_mode = RX_STREAM;
    int        mode_left = 0;
    t_hist_row want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected row for letter %0d", o_letter_index);
                    end
                end else begin
                    want = expected_rows.pop_front();
                    compare_field("letter_index", want.letter, o_letter_index);
                    compare_field("letter_count", want.count, o_letter_count);
                    compare_field("letters_total", want.letters, o_letters_total);
                    compare_field("space_total", want.spaces, o_space_total);
                    compare_field("other_total", want.others, o_other_total);
                    compare_field("top_letter", want.top, o_top_letter);
                    compare_field("top_count", want.top_cnt, o_top_count);
                    compare_field("final_entry", want.last, o_final_entry);
                end
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STREAM: begin
                    i_out_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    i_out_ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    i_out_ready <= (mode_left % 6 == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            sentence_bytes.push_back(s[i]);
        end
        sentence_bytes.push_back(CHAR_NUL);
    endtask

    initial begin
        logic [7:0] boundary_bytes [12];
        int         random_bytes;
        int         len;
        int         span;
        int         pick;
        logic [7:0] b;

        boundary_bytes = '{8'h01, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F,
                           8'h80, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A};
        random_bytes = 0;

        // An empty sentence reports all zero with A on top.
        add_text("");
        // Mixed case, a space and punctuation.
        add_text("Hi all!");
        // B gets there first, then A ties it and takes over as the lower letter.
        add_text("ba");
        // Case-fold borders, DEL and bytes with the top bit set.
        foreach (boundary_bytes[i]) begin
            sentence_bytes.push_back(boundary_bytes[i]);
        end
        sentence_bytes.push_back(CHAR_NUL);

        // Random sentences, mostly letters from a span of random width starting at A, to provoke ties.
        while (random_bytes < 125) begin
            len  = $urandom_range(0, 14);
            span = $urandom_range(0, LETTER_COUNT - 1);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    b = ($urandom_range(0, 1) == 1) ? CHAR_LOWER_A : CHAR_UPPER_A;
                    b = b + 8'($urandom_range(0, span));
                end else if (pick < 75) begin
                    b = CHAR_SPACE;
                end else begin
                    b = 8'($urandom_range(1, 255));
                end
                sentence_bytes.push_back(b);
            end
            sentence_bytes.push_back(CHAR_NUL);
            random_bytes += len + 1;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sentence_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        // Give any stray row a chance to show up.
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: letter_frequency_histogram_unit.f
hdl/lfh_pkg.sv
hdl/lfh_ctrl.sv
hdl/lfh_dp.sv
hdl/letter_frequency_histogram_unit.sv
hdl/lfh_checker.sv
verif/tb.sv
